@@ sv/bbs_pkg.sv @@
// Shared types and constants of the Bollinger band crossover block.
package bbs_pkg;

    localparam int LEN_BITS        = 11;
    localparam int FACTOR_BITS     = 16;
    localparam int F2_BITS         = 2 * FACTOR_BITS;
    localparam int FRAC_BITS       = 8;
    localparam int DIGIT_BITS      = 8;
    localparam int INDEX_BITS      = 32;
    localparam int PRICE_PORT_BITS = 24;
    localparam int ADDR_BITS       = 3;
    localparam int DATA_BITS       = 32;

    localparam logic [LEN_BITS-1:0]    LEN_RESET    = 11'd20;
    localparam logic [FACTOR_BITS-1:0] FACTOR_RESET = 16'd512;

    // Register index, taken from paddr[2]
    localparam logic REG_WINDOW_LENGTH = 1'b0;
    localparam logic REG_BAND_FACTOR   = 1'b1;

    localparam logic ACT_BUY  = 1'b0;
    localparam logic ACT_SELL = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD,
        ST_UPDATE,
        ST_SCALE,
        ST_CHECK,
        ST_MUL_GO,
        ST_MUL_WAIT,
        ST_EMIT
    } t_state;

    typedef enum logic [1:0] {
        OP_LQ,
        OP_SS,
        OP_FD,
        OP_AA
    } t_mul_op;

    typedef struct packed {
        logic [LEN_BITS-1:0]    window_length;
        logic [FACTOR_BITS-1:0] band_factor;
        logic                   clear;
    } t_cfg;

endpackage

@@ sv/bollinger_band_signal.sv @@
// Top level of the Bollinger band crossover signal block, with its register port.
// The block takes a new item only once it is through with the last one; the band test runs
//   only on a full window, on the shared digit-serial multiplier with
//   ND = ceil(max(PRICE_BITS+clog2(MAX_WINDOW+1)+8, 32)/8) digits of the shared multiplier.
// Reset (synchronous, active low) empties the window, clears position and sample count.
module bollinger_band_signal
    import bbs_pkg::*;
#(
    parameter int MAX_WINDOW = 1024,
    parameter int PRICE_BITS = 24
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    // register port
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [ADDR_BITS-1:0]       paddr,
    input  logic [DATA_BITS-1:0]       pwdata,
    output logic [DATA_BITS-1:0]       prdata,
    output logic                       pready,
    // price items in
    input  logic                       i_valid,
    input  logic [PRICE_PORT_BITS-1:0] i_price,
    output logic                       o_stall,
    // signal items out
    output logic                       o_valid,
    input  logic                       i_stall,
    output logic                       o_action,
    output logic [INDEX_BITS-1:0]      o_sample_index,
    output logic [PRICE_PORT_BITS-1:0] o_trigger_price
);

    logic [LEN_BITS-1:0]    r_window_length;
    logic [FACTOR_BITS-1:0] r_band_factor;
    logic                   wr_en;
    t_cfg                   cfg;

    // Zero-wait-state port: a write lands in the access phase
    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window_length <= LEN_RESET;
            r_band_factor   <= FACTOR_RESET;
        end else if (wr_en) begin
            unique case (paddr[2])
                REG_WINDOW_LENGTH: r_window_length <= pwdata[LEN_BITS-1:0];
                REG_BAND_FACTOR:   r_band_factor   <= pwdata[FACTOR_BITS-1:0];
                default:           r_band_factor   <= r_band_factor;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            REG_WINDOW_LENGTH: prdata = DATA_BITS'(r_window_length);
            REG_BAND_FACTOR:   prdata = DATA_BITS'(r_band_factor);
            default:           prdata = '0;
        endcase
    end

    // A length write empties the window on the same edge; position and count stay
    assign cfg.window_length = r_window_length;
    assign cfg.band_factor   = r_band_factor;
    assign cfg.clear         = wr_en && (paddr[2] == REG_WINDOW_LENGTH);

    bbs_core #(
        .MAX_WINDOW (MAX_WINDOW),
        .PRICE_BITS (PRICE_BITS)
    ) u_core (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg           (cfg),
        .i_valid         (i_valid),
        .i_price         (i_price),
        .o_stall         (o_stall),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_action        (o_action),
        .o_sample_index  (o_sample_index),
        .o_trigger_price (o_trigger_price)
    );

endmodule

@@ sv/bbs_mem.sv @@
// Price ring memory: one write port, one read port, registered read data.
module bbs_mem #(
    parameter int DEPTH = 1024,
    parameter int WIDTH = 24
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Read before write: a read of the entry being written returns the old value
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ sv/bbs_mul.sv @@
// Shared digit-serial multiplier: one 8-bit digit of the B operand per cycle.
module bbs_mul
    import bbs_pkg::*;
#(
    parameter int A_BITS = 74,
    parameter int B_BITS = 45
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_start,
    input  logic [A_BITS-1:0]        i_a,
    input  logic [B_BITS-1:0]        i_b,
    output logic                     o_done,
    output logic [A_BITS+B_BITS-1:0] o_prod
);

    localparam int P_BITS = A_BITS + B_BITS;
    localparam int ND     = (B_BITS + DIGIT_BITS - 1) / DIGIT_BITS;
    localparam int CNTW   = (ND > 1) ? $clog2(ND) : 1;

    logic              r_busy;
    logic              r_done;
    logic [CNTW-1:0]   r_cnt;
    logic [P_BITS-1:0] r_acc;
    logic [P_BITS-1:0] r_a;
    logic [B_BITS-1:0] r_b;
    logic              last_step;

    assign last_step = (r_cnt == CNTW'(ND - 1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= r_busy && last_step;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (last_step) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    // Accumulate one partial product, then advance both operands by a digit
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_acc <= '0;
            r_a   <= P_BITS'(i_a);
            r_b   <= i_b;
        end else if (r_busy) begin
            r_acc <= r_acc + P_BITS'(r_a * r_b[DIGIT_BITS-1:0]);
            r_a   <= r_a << DIGIT_BITS;
            r_b   <= r_b >> DIGIT_BITS;
        end
    end

    assign o_done = r_done;
    assign o_prod = r_acc;

endmodule

@@ sv/bbs_core.sv @@
// Window bookkeeping, band test sequencer and result register.
module bbs_core
    import bbs_pkg::*;
#(
    parameter int MAX_WINDOW = 1024,
    parameter int PRICE_BITS = 24
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  t_cfg                       i_cfg,
    input  logic                       i_valid,
    input  logic [PRICE_PORT_BITS-1:0] i_price,
    output logic                       o_stall,
    output logic                       o_valid,
    input  logic                       i_stall,
    output logic                       o_action,
    output logic [INDEX_BITS-1:0]      o_sample_index,
    output logic [PRICE_PORT_BITS-1:0] o_trigger_price
);

    localparam int AW = $clog2(MAX_WINDOW);
    localparam int LW = $clog2(MAX_WINDOW + 1);
    localparam int LX = LW + 1;
    localparam int P  = PRICE_BITS;
    localparam int SW = P + LW;
    localparam int QW = 2 * P + LW;
    localparam int DW = 2 * P + 2 * LW;
    localparam int EW = SW + FRAC_BITS;
    localparam int MB = (EW > F2_BITS) ? EW : F2_BITS;
    localparam int MP = DW + MB;
    localparam int CW = (LW > LEN_BITS) ? LW : LEN_BITS;

    t_state  r_state, n_state;
    t_mul_op r_op;

    logic [P-1:0]          r_price;
    logic [LW-1:0]         r_len;
    logic [AW-1:0]         r_wp;
    logic [LW-1:0]         r_fill;
    logic [SW-1:0]         r_sum;
    logic [QW-1:0]         r_sq;
    logic [2*P-1:0]        r_psq;
    logic [SW-1:0]         r_lp;
    logic [F2_BITS-1:0]    r_f2;
    logic [SW-1:0]         r_e;
    logic                  r_dir;
    logic [DW-1:0]         r_lq;
    logic [DW-1:0]         r_dev;
    logic [MP-1:0]         r_fd;
    logic                  r_holding;
    logic [INDEX_BITS-1:0] r_count;
    logic [INDEX_BITS-1:0] r_idx;

    logic                       r_out_valid;
    logic                       r_action;
    logic [INDEX_BITS-1:0]      r_out_idx;
    logic [PRICE_PORT_BITS-1:0] r_out_price;

    logic [CW-1:0] raw_len;
    logic [LW-1:0] len_eff;
    logic [LX-1:0] wp_ext, len_ext, old_pos_w;
    logic [AW-1:0] old_pos;
    logic [P-1:0]  mem_rdata;
    logic [2*P-1:0] old_sq;
    logic          was_full, is_full, s_gt, l_gt, band_ok, out_free, accept;
    logic          mem_we, mul_start, mul_done;
    logic [DW-1:0] mul_a;
    logic [MB-1:0] mul_b;
    logic [MP-1:0] mul_prod;
    logic [EW-1:0] e_scaled;

    // A length of zero acts as one, anything above the window depth as the depth
    assign raw_len = CW'(i_cfg.window_length);
    always_comb begin
        if (raw_len == '0) begin
            len_eff = LW'(1);
        end else if (raw_len > CW'(MAX_WINDOW)) begin
            len_eff = LW'(MAX_WINDOW);
        end else begin
            len_eff = LW'(raw_len);
        end
    end

    // Oldest entry of the window, one window length behind the write pointer
    assign wp_ext    = LX'(r_wp);
    assign len_ext   = LX'(r_len);
    assign old_pos_w = (wp_ext >= len_ext) ? (wp_ext - len_ext)
                                           : (wp_ext + LX'(MAX_WINDOW) - len_ext);
    assign old_pos   = AW'(old_pos_w);

    assign old_sq   = mem_rdata * mem_rdata;
    assign was_full = (r_fill >= r_len);
    assign is_full  = (r_fill >= r_len);
    assign s_gt     = (r_sum > r_lp);
    assign l_gt     = (r_lp > r_sum);
    assign band_ok  = (s_gt && !r_holding) || (l_gt && r_holding);
    assign out_free = !r_out_valid || !i_stall;
    assign accept   = i_valid && !o_stall;
    assign e_scaled = {r_e, {FRAC_BITS{1'b0}}};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state   = r_state;
        o_stall   = 1'b1;
        mem_we    = 1'b0;
        mul_start = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_stall = 1'b0;
                if (i_valid) begin
                    n_state = ST_LOAD;
                end
            end
            ST_LOAD: begin
                mem_we  = 1'b1;
                n_state = ST_UPDATE;
            end
            ST_UPDATE: begin
                n_state = ST_SCALE;
            end
            ST_SCALE: begin
                n_state = is_full ? ST_CHECK : ST_IDLE;
            end
            ST_CHECK: begin
                n_state = band_ok ? ST_MUL_GO : ST_IDLE;
            end
            ST_MUL_GO: begin
                mul_start = 1'b1;
                n_state   = ST_MUL_WAIT;
            end
            ST_MUL_WAIT: begin
                if (mul_done) begin
                    if (r_op == OP_AA) begin
                        n_state = (r_fd < mul_prod) ? ST_EMIT : ST_IDLE;
                    end else begin
                        n_state = ST_MUL_GO;
                    end
                end
            end
            ST_EMIT: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Window state, position and sample count: reset clears all, a length write only the window
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp      <= '0;
            r_fill    <= '0;
            r_sum     <= '0;
            r_sq      <= '0;
            r_holding <= 1'b0;
            r_count   <= '0;
        end else begin
            if (i_cfg.clear) begin
                r_wp   <= '0;
                r_fill <= '0;
                r_sum  <= '0;
                r_sq   <= '0;
            end else if (r_state == ST_UPDATE) begin
                if (was_full) begin
                    r_sum <= r_sum - SW'(mem_rdata) + SW'(r_price);
                    r_sq  <= r_sq - QW'(old_sq) + QW'(r_psq);
                end else begin
                    r_fill <= r_fill + 1'b1;
                    r_sum  <= r_sum + SW'(r_price);
                    r_sq   <= r_sq + QW'(r_psq);
                end
                r_wp <= (r_wp == AW'(MAX_WINDOW - 1)) ? '0 : r_wp + 1'b1;
            end
            if (accept) begin
                r_count <= r_count + 1'b1;
            end
            if (r_state == ST_EMIT && out_free) begin
                r_holding <= (r_dir == ACT_BUY);
            end
        end
    end

    // Per-item working registers
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_price <= i_price[P-1:0];
            r_len   <= len_eff;
            r_idx   <= r_count;
        end
        if (r_state == ST_LOAD) begin
            r_psq <= r_price * r_price;
        end
        if (r_state == ST_SCALE) begin
            r_lp <= SW'(SW'(r_len) * SW'(r_price));
        end
        if (r_state == ST_CHECK) begin
            r_e   <= s_gt ? (r_sum - r_lp) : (r_lp - r_sum);
            r_dir <= s_gt ? ACT_BUY : ACT_SELL;
            r_f2  <= F2_BITS'(i_cfg.band_factor) * F2_BITS'(i_cfg.band_factor);
            r_op  <= OP_LQ;
        end
        if (r_state == ST_MUL_WAIT && mul_done) begin
            case (r_op)
                OP_LQ: begin
                    r_lq <= DW'(mul_prod);
                    r_op <= OP_SS;
                end
                OP_SS: begin
                    r_dev <= r_lq - DW'(mul_prod);
                    r_op  <= OP_FD;
                end
                OP_FD: begin
                    r_fd <= mul_prod;
                    r_op <= OP_AA;
                end
                default: begin
                    r_op <= OP_AA;
                end
            endcase
        end
    end

    // Operands of the shared multiplier for each step of the band test
    always_comb begin
        case (r_op)
            OP_LQ: begin
                mul_a = DW'(r_sq);
                mul_b = MB'(r_len);
            end
            OP_SS: begin
                mul_a = DW'(r_sum);
                mul_b = MB'(r_sum);
            end
            OP_FD: begin
                mul_a = r_dev;
                mul_b = MB'(r_f2);
            end
            default: begin
                mul_a = DW'(e_scaled);
                mul_b = MB'(e_scaled);
            end
        endcase
    end

    // Result register: hold until taken, refill as it drains
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == ST_EMIT && out_free) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_EMIT && out_free) begin
            r_action    <= r_dir;
            r_out_idx   <= r_idx;
            r_out_price <= PRICE_PORT_BITS'(r_price);
        end
    end

    bbs_mem #(
        .DEPTH (MAX_WINDOW),
        .WIDTH (P)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (r_wp),
        .i_wdata (r_price),
        .i_raddr (old_pos),
        .o_rdata (mem_rdata)
    );

    bbs_mul #(
        .A_BITS (DW),
        .B_BITS (MB)
    ) u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (mul_start),
        .i_a     (mul_a),
        .i_b     (mul_b),
        .o_done  (mul_done),
        .o_prod  (mul_prod)
    );

    assign o_valid         = r_out_valid;
    assign o_action        = r_action;
    assign o_sample_index  = r_out_idx;
    assign o_trigger_price = r_out_price;

endmodule

@@ sv/bbs_checker.sv @@
// Port-level checks of the Bollinger band block and their bind to the top level.
module bbs_checker
    import bbs_pkg::*;
(
    input logic                       i_clk,
    input logic                       i_rst_n,
    input logic                       i_valid,
    input logic                       o_stall,
    input logic                       o_valid,
    input logic                       i_stall,
    input logic                       o_action,
    input logic [INDEX_BITS-1:0]      o_sample_index,
    input logic [PRICE_PORT_BITS-1:0] o_trigger_price
);

    logic r_expect;

    // Position starts flat, so signals alternate buy, sell, buy...
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_expect <= ACT_BUY;
        end else if (o_valid && !i_stall) begin
            r_expect <= ~o_action;
        end
    end

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> o_stall)
        else $error("input not stalled after an item was taken");

    a_result_from_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> $past(o_stall))
        else $error("result appeared while the block was idle");

    a_alternating: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_action == r_expect))
        else $error("buy and sell signals do not alternate");

    a_hold_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=>
            (o_valid && $stable(o_sample_index) && $stable(o_trigger_price)))
        else $error("stalled result changed");

endmodule

bind bollinger_band_signal bbs_checker u_bbs_checker (.*);

@@ bench/tb_bollinger_band_signal.sv @@
// Testbench for the Bollinger band crossover signal block.
module tb_bollinger_band_signal;
    import bbs_pkg::*;

    localparam int WIN_DEPTH     = 1024;
    // Settle time before a register write: covers the band test with margin
    localparam int SETTLE_CYCLES = 64;
    localparam logic [23:0] PRICE_MAX = 24'hFFFFFF;

    // One buy or sell signal as it leaves the block
    typedef struct packed {
        logic        action;
        logic [31:0] index;
        logic [23:0] price;
    } crossing_t;

    typedef enum logic [1:0] {
        ROW_ITEM,
        ROW_LEN,
        ROW_FACTOR
    } row_kind_t;

    // Directed row: a price item or a register write; typed rows carry their own answer
    typedef struct packed {
        row_kind_t   kind;
        logic [31:0] value;
        logic        typed;
        logic        fires;
        logic        action;
        logic [31:0] index;
    } dir_row_t;

    localparam int DIR_ROWS = 33;

    logic        i_clk   = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        psel    = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite  = 1'b0;
    logic [ADDR_BITS-1:0]       paddr  = '0;
    logic [DATA_BITS-1:0]       pwdata = '0;
    logic [DATA_BITS-1:0]       prdata;
    logic                       pready;
    logic                       i_valid = 1'b0;
    logic [PRICE_PORT_BITS-1:0] i_price = '0;
    logic                       o_stall;
    logic                       o_valid;
    logic                       i_stall = 1'b0;
    logic                       o_action;
    logic [INDEX_BITS-1:0]      o_sample_index;
    logic [PRICE_PORT_BITS-1:0] o_trigger_price;

    bollinger_band_signal dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready),
        .i_valid         (i_valid),
        .i_price         (i_price),
        .o_stall         (o_stall),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_action        (o_action),
        .o_sample_index  (o_sample_index),
        .o_trigger_price (o_trigger_price)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Signals still owed by the block, oldest first
    crossing_t   crossing_q [$];
    int unsigned fail_count = 0;

    // Shadow of the block: price window, running sums, position and registers
    logic [23:0] win_mem [WIN_DEPTH];
    logic [9:0]  win_wp     = '0;
    logic [10:0] win_fill   = '0;
    logic [63:0] win_sum    = '0;
    logic [63:0] win_sqsum  = '0;
    logic        holding    = 1'b0;
    logic [31:0] item_count = '0;
    logic [10:0] len_reg    = LEN_RESET;
    logic [15:0] factor_reg = FACTOR_RESET;

    // Sender and receiver pacing
    int unsigned burst_left = 0;
    logic [23:0] last_price = 24'd100000;
    logic [1:0]  stall_mode = 2'd0;
    int unsigned mode_left  = 0;
    int unsigned stall_run  = 0;

    dir_row_t dir_table [0:DIR_ROWS-1];

    // Advance the shadow window by one price and work out the signal, if any.
    // The band test is done exactly: F*F*(L*Q - S*S) against (256*|S - L*p|)^2.
    task automatic predict_crossing(input logic [23:0] p, output bit fired,
                                    output crossing_t res);
        logic [10:0]  len;
        logic [9:0]   old_pos;
        logic [63:0]  old, lp, band_gap;
        logic [31:0]  f2;
        logic [127:0] spread, scaled, gap_sq;
        bit           cand;
        fired = 1'b0;
        cand  = 1'b0;
        res   = '0;
        len = (len_reg == 11'd0) ? 11'd1 :
              (len_reg > 11'(WIN_DEPTH)) ? 11'(WIN_DEPTH) : len_reg;
        res.index  = item_count;
        res.price  = p;
        item_count = item_count + 32'd1;

        // Full window: drop the oldest price from both sums
        if (win_fill >= len) begin
            old_pos   = win_wp - len[9:0];
            old       = 64'(win_mem[old_pos]);
            win_sum   = win_sum - old;
            win_sqsum = win_sqsum - old * old;
        end else begin
            win_fill = win_fill + 11'd1;
        end
        win_mem[win_wp] = p;
        win_wp          = win_wp + 10'd1;
        win_sum         = win_sum + 64'(p);
        win_sqsum       = win_sqsum + 64'(p) * 64'(p);

        if (win_fill >= len) begin
            lp     = 64'(len) * 64'(p);
            f2     = 32'(factor_reg) * 32'(factor_reg);
            spread = 128'(len) * 128'(win_sqsum) - 128'(win_sum) * 128'(win_sum);
            scaled = spread * 128'(f2);
            if (win_sum > lp && !holding) begin
                band_gap   = (win_sum - lp) << 8;
                res.action = ACT_BUY;
                cand       = 1'b1;
            end else if (lp > win_sum && holding) begin
                band_gap   = (lp - win_sum) << 8;
                res.action = ACT_SELL;
                cand       = 1'b1;
            end
            if (cand) begin
                gap_sq = 128'(band_gap) * 128'(band_gap);
                if (scaled < gap_sq) begin
                    fired   = 1'b1;
                    holding = (res.action == ACT_BUY);
                end
            end
        end
    endtask

    // One register transfer: setup phase, access phase until pready, then an idle phase
    task automatic apb_xfer(input logic idx, input bit wr, input logic [31:0] wdata,
                            output logic [31:0] rdata);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= {idx, 2'b00};
        pwdata  <= wdata;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        rdata = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic reg_check(input logic idx, input logic [31:0] want);
        logic [31:0] got;
        apb_xfer(idx, 1'b0, '0, got);
        if (got !== want) begin
            $error("prdata[%0d]: expected %0d, got %0d", idx, want, got);
            fail_count++;
        end
    endtask

    // Write a register, mirror it in the shadow, and read it back
    task automatic reg_write(input logic idx, input logic [31:0] value);
        logic [31:0] unused;
        apb_xfer(idx, 1'b1, value, unused);
        if (idx == REG_WINDOW_LENGTH) begin
            len_reg   = value[10:0];
            win_wp    = '0;
            win_fill  = '0;
            win_sum   = '0;
            win_sqsum = '0;
            reg_check(idx, value & 32'h7FF);
        end else begin
            factor_reg = value[15:0];
            reg_check(idx, value & 32'hFFFF);
        end
    endtask

    // Drop valid and hold until every owed signal is out; optionally let the
    // block finish an item that gives no signal
    task automatic settle_block(input bit full);
        i_valid <= 1'b0;
        do @(posedge i_clk); while (crossing_q.size() != 0);
        if (full) repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Offer one price, in bursts with random gaps, and record what it should cause
    task automatic send_price(input logic [23:0] p, input bit typed, input bit typed_fires,
                              input crossing_t typed_res);
        int unsigned gap;
        bit          fired;
        crossing_t   res;
        if (burst_left == 0) begin
            burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(40, 80)
                                                     : $urandom_range(1, 20);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap != 0) begin
                i_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        i_valid <= 1'b1;
        i_price <= p;
        do @(posedge i_clk); while (o_stall);
        predict_crossing(p, fired, res);
        if (typed) begin
            fired = typed_fires;
            res   = typed_res;
        end
        if (fired) crossing_q = {crossing_q, res};
    endtask

    // Random walk with flat runs, full-range spikes and the two rails
    function automatic logic [23:0] next_price();
        longint      v;
        longint      step;
        int unsigned sel;
        sel = $urandom_range(0, 19);
        if (sel < 13) begin
            step = longint'($urandom_range(0, 1 << $urandom_range(0, 16)));
            v    = longint'(last_price) + ($urandom_range(0, 1) ? step : -step);
            if (v < 0) v = 0;
            if (v > longint'(PRICE_MAX)) v = longint'(PRICE_MAX);
        end else if (sel < 15) begin
            v = longint'(last_price);
        end else if (sel < 18) begin
            v = longint'($urandom & 32'h00FFFFFF);
        end else if (sel == 18) begin
            v = 0;
        end else begin
            v = longint'(PRICE_MAX);
        end
        last_price = 24'(v);
        return last_price;
    endfunction

    // Mostly small factors, so that bands are crossed often; now and then the rails
    function automatic logic [31:0] pick_band_factor();
        int unsigned sel;
        sel = $urandom_range(0, 7);
        if (sel < 2) return 32'd0;
        if (sel == 2) return 32'd65535;
        return 32'($urandom_range(1, 400));
    endfunction

    // Receiver: free-running, random stalls, or long stall and release runs
    always @(posedge i_clk) begin
        if (mode_left == 0) begin
            mode_left  <= $urandom_range(64, 400);
            stall_mode <= 2'($urandom_range(0, 2));
        end else begin
            mode_left <= mode_left - 1;
        end
        case (stall_mode)
            2'd0: begin
                i_stall <= 1'b0;
            end
            2'd1: begin
                i_stall <= ($urandom_range(0, 3) == 0);
            end
            default: begin
                if (stall_run == 0) begin
                    stall_run <= $urandom_range(1, 40);
                    i_stall   <= !i_stall;
                end else begin
                    stall_run <= stall_run - 1;
                end
            end
        endcase
    end

    // Compare every accepted signal with the oldest one owed
    always @(posedge i_clk) begin : signal_check
        crossing_t want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (crossing_q.size() == 0) begin
                $error("unexpected signal: action %0d index %0d price %0d",
                       o_action, o_sample_index, o_trigger_price);
                fail_count++;
            end else begin
                want = crossing_q.pop_front();
                if (o_action !== want.action) begin
                    $error("action: expected %0d, got %0d", want.action, o_action);
                    fail_count++;
                end
                if (o_sample_index !== want.index) begin
                    $error("sample_index: expected %0d, got %0d", want.index, o_sample_index);
                    fail_count++;
                end
                if (o_trigger_price !== want.price) begin
                    $error("trigger_price: expected %0d, got %0d", want.price, o_trigger_price);
                    fail_count++;
                end
            end
        end
    end

    initial begin : stimulus
        crossing_t   typed_res;
        logic [10:0] long_len;
        logic [10:0] len_steps [5];
        // Two-entry window, zero factor: any move away from the mean signals.
        // Then the factor boundary for a two-entry window (255 fires, 256 ties),
        // the largest factor, window lengths zero and above the maximum.
        dir_table = '{
            '{ROW_LEN,    32'd2,        1'b0, 1'b0, ACT_BUY,  32'd0},
            '{ROW_FACTOR, 32'd0,        1'b0, 1'b0, ACT_BUY,  32'd0},
            '{ROW_ITEM,   32'd100,      1'b1, 1'b0, ACT_BUY,  32'd0},
            '{ROW_ITEM,   32'd50,       1'b1, 1'b1, ACT_BUY,  32'd1},
            '{ROW_ITEM,   32'd50,       1'b1, 1'b0, ACT_BUY,  32'd2},
            '{ROW_ITEM,   32'd200,      1'b1, 1'b1, ACT_SELL, 32'd3},
            '{ROW_ITEM,   32'hFFFFFF,   1'b1, 1'b0, ACT_BUY,  32'd4},
            '{ROW_ITEM,   32'd0,        1'b1, 1'b1, ACT_BUY,  32'd5},
            '{ROW_ITEM,   32'hFFFFFF,   1'b1, 1'b1, ACT_SELL, 32'd6},
            '{ROW_ITEM,   32'hFFFFFF,   1'b1, 1'b0, ACT_BUY,  32'd7},
            '{ROW_FACTOR, 32'd255,      1'b0, 1'b0, ACT_BUY,  32'd0},
            '{ROW_ITEM,   32'd10,       1'b1, 1'b1, ACT_BUY,  32'd8},
            '{ROW_ITEM,   32'd20,       1'b1, 1'b1, ACT_SELL, 32'd9},
            '{ROW_FACTOR, 32'd256,      1'b0, 1'b0, ACT_BUY,  32'd0},
            '{ROW_ITEM,   32'd5,        1'b1, 1'b0, ACT_BUY,  32'd10},
            '{ROW_ITEM,   32'd30,       1'b1, 1'b0, ACT_BUY,  32'd11},
            '{ROW_FACTOR, 32'd65535,    1'b0, 1'b0, ACT_BUY,  32'd0},
            '{ROW_ITEM,   32'd0,        1'b1, 1'b0, ACT_BUY,  32'd12},
            '{ROW_LEN,    32'd0,        1'b0, 1'b0, ACT_BUY,  32'd0},
            '{ROW_ITEM,   32'd7,        1'b1, 1'b0, ACT_BUY,  32'd13},
            '{ROW_ITEM,   32'd0,        1'b1, 1'b0, ACT_BUY,  32'd14},
            '{ROW_LEN,    32'd2047,     1'b0, 1'b0, ACT_BUY,  32'd0},
            '{ROW_ITEM,   32'hABCDEF,   1'b1, 1'b0, ACT_BUY,  32'd15},
            '{ROW_ITEM,   32'd1,        1'b1, 1'b0, ACT_BUY,  32'd16},
            '{ROW_LEN,    32'd3,        1'b0, 1'b0, ACT_BUY,  32'd0},
            '{ROW_FACTOR, 32'd128,      1'b0, 1'b0, ACT_BUY,  32'd0},
            '{ROW_ITEM,   32'd1000,     1'b0, 1'b0, ACT_BUY,  32'd0},
            '{ROW_ITEM,   32'd3000,     1'b0, 1'b0, ACT_BUY,  32'd0},
            '{ROW_ITEM,   32'd2000,     1'b0, 1'b0, ACT_BUY,  32'd0},
            '{ROW_ITEM,   32'd500,      1'b0, 1'b0, ACT_BUY,  32'd0},
            '{ROW_ITEM,   32'd4000,     1'b0, 1'b0, ACT_BUY,  32'd0},
            '{ROW_ITEM,   32'd4000,     1'b0, 1'b0, ACT_BUY,  32'd0},
            '{ROW_ITEM,   32'hFFFFFF,   1'b0, 1'b0, ACT_BUY,  32'd0}
        };
        len_steps = '{11'd1, 11'd2047, 11'd2, 11'd1024, 11'd5};

        // Hold reset, then check the register reset values
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        reg_check(REG_WINDOW_LENGTH, 32'(LEN_RESET));
        reg_check(REG_BAND_FACTOR, 32'(FACTOR_RESET));

        // Walk the directed table; registers change only once the block is quiet
        for (int r = 0; r < DIR_ROWS; r++) begin
            case (dir_table[r].kind)
                ROW_LEN: begin
                    settle_block(1'b1);
                    reg_write(REG_WINDOW_LENGTH, dir_table[r].value);
                end
                ROW_FACTOR: begin
                    settle_block(1'b1);
                    reg_write(REG_BAND_FACTOR, dir_table[r].value);
                end
                default: begin
                    typed_res.action = dir_table[r].action;
                    typed_res.index  = dir_table[r].index;
                    typed_res.price  = dir_table[r].value[23:0];
                    send_price(dir_table[r].value[23:0], dir_table[r].typed,
                               dir_table[r].fires, typed_res);
                end
            endcase
        end

        // Short random phases over the window length extremes
        foreach (len_steps[k]) begin
            settle_block(1'b1);
            reg_write(REG_WINDOW_LENGTH, 32'(len_steps[k]));
            reg_write(REG_BAND_FACTOR, pick_band_factor());
            repeat (16) send_price(next_price(), 1'b0, 1'b0, '0);
        end

        // One long stretch on a small window;
        // only the factor changes, so the window is never emptied
        long_len = 11'($urandom_range(6, 14));
        settle_block(1'b1);
        reg_write(REG_WINDOW_LENGTH, 32'(long_len));
        for (int sub = 0; sub < 4; sub++) begin
            settle_block(1'b1);
            case (sub)
                0:       reg_write(REG_BAND_FACTOR, 32'd0);
                2:       reg_write(REG_BAND_FACTOR, 32'd65535);
                default: reg_write(REG_BAND_FACTOR, 32'($urandom_range(64, 400)));
            endcase
            for (int k = 0; k < 185; k++) begin
                // Now and then hold the sender until every owed signal is out
                if (k % 97 == 50) settle_block(1'b0);
                send_price(next_price(), 1'b0, 1'b0, '0);
            end
        end

        settle_block(1'b1);
        if (fail_count == 0) begin
            $display("tb_bollinger_band_signal OK");
        end else begin
            $display("tb_bollinger_band_signal NOT OK");
        end
        $finish;
    end

    // Stop a hung run
    initial begin
        #20_000_000;
        $display("tb_bollinger_band_signal NOT OK");
        $finish;
    end

endmodule
